// File: hdl/tns_pkg.sv
// ============================================================================
// tns_pkg
// Shared constants, field widths and the control bundle used by the
// top-N selector and its storage cells.
// ============================================================================
`default_nettype none

package tns_pkg;

  // Store depth and field widths.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;

  // Limit register width and its reset value.
  localparam int unsigned LIM_W = 5;
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16);

  // Width of the held-pair count, and a width that holds both count and limit.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  // Input item kinds carried on tuser.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en; // place the offered pair into the sorted chain
    logic grow;   // the chain gains one valid entry with this insert
    logic shift;  // rotate the valid part of the chain toward the head
  } cell_ctrl_t;

endpackage : tns_pkg

`default_nettype wire

// File: hdl/tns_cell.sv
// ============================================================================
// tns_cell
// One storage cell of the sorted chain: holds a key/value pair and its valid
// bit, and takes a new pair, either neighbor's pair or the head pair.
// ============================================================================
`default_nettype none

module tns_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  tns_pkg::cell_ctrl_t      ctrl_i,
  input  wire [tns_pkg::KEY_W-1:0] in_key_i,
  input  wire [tns_pkg::VAL_W-1:0] in_value_i,
  input  wire                      prev_stay_i,
  input  wire                      prev_valid_i,
  input  wire [tns_pkg::KEY_W-1:0] prev_key_i,
  input  wire [tns_pkg::VAL_W-1:0] prev_value_i,
  input  wire                      next_valid_i,
  input  wire [tns_pkg::KEY_W-1:0] next_key_i,
  input  wire [tns_pkg::VAL_W-1:0] next_value_i,
  input  wire [tns_pkg::KEY_W-1:0] head_key_i,
  input  wire [tns_pkg::VAL_W-1:0] head_value_i,
  output logic [tns_pkg::KEY_W-1:0] key_o,
  output logic [tns_pkg::VAL_W-1:0] value_o,
  output logic                      valid_o,
  output logic                      stay_o,
  output logic                      lt_o
);
  import tns_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             valid_q, valid_d;
  logic             stay;

  // A held key at least as large as the offered one keeps its place, so a
  // newer equal key lands below it.
  assign stay = valid_q && (key_q >= in_key_i);

  // Next contents: insert shifts down, dump rotates up with wrap to the head.
  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.ins_en) begin
      if (!stay) begin
        if (prev_stay_i) begin
          key_d   = in_key_i;
          value_d = in_value_i;
        end else begin
          key_d   = prev_key_i;
          value_d = prev_value_i;
        end
      end
      if (ctrl_i.grow) begin
        valid_d = valid_q | prev_valid_i;
      end
    end else if (ctrl_i.shift && valid_q) begin
      if (next_valid_i) begin
        key_d   = next_key_i;
        value_d = next_value_i;
      end else begin
        key_d   = head_key_i;
        value_d = head_value_i;
      end
    end
  end

  // Valid bit is control state and resets; the payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign valid_o = valid_q;
  assign stay_o  = stay;
  assign lt_o    = valid_q && !stay;

endmodule : tns_cell

`default_nettype wire

// File: hdl/top_n_selector.sv
// ============================================================================
// top_n_selector
// Keeps the largest key/value pairs seen so far in a sorted chain of cells
// and streams them out, largest key first, on request.
// ============================================================================
// On an insert transaction (tuser 0) every cell compares its key with the
// offered key at once and the chain shifts down below the insertion point
// in a single step, so inserts are accepted back to back. A dump
// transaction (tuser 1) rotates the valid part of the chain past the head
// cell, one pair per cycle while the output is not stalled; an empty store
// gives a single empty result. No input is accepted until the last pair has
// entered the output register. The limit register may only be written while
// the block is idle; 0 acts as 1 and values above the depth act as the
// depth. Lowering the limit below the held count leaves the store full at
// its present count.
`default_nettype none

module top_n_selector (
  input  wire        clk_i,
  input  wire        rst_ni,
  // Limit register write port.
  input  wire        cfg_we_i,
  input  wire [4:0]  cfg_wdata_i,  // count_limit
  // Input stream.
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [63:0] s_axis_tdata,  // [31:0] key, [63:32] value
  input  wire        s_axis_tuser,  // [0] kind
  // Output stream.
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [63:0] m_axis_tdata, // [31:0] out_key, [63:32] out_value
  output logic       m_axis_tlast,  // last
  output logic       m_axis_tuser   // [0] empty_res
);
  import tns_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [LIM_W-1:0] limit_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;

  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  logic             in_acc;
  logic             ins_acc;
  logic             dump_acc;

  logic [CMP_W-1:0] lim_ext;
  logic [CMP_W-1:0] eff_lim;
  logic             room;
  logic             evict;

  cell_ctrl_t ctrl;

  logic [KEY_W-1:0] cell_key   [DEPTH];
  logic [VAL_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_stay;
  logic [DEPTH-1:0] cell_lt;

  logic             out_free;
  logic             emit;
  logic             out_valid_q;
  logic [KEY_W-1:0] out_key_q, out_key_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;
  logic             out_last_q, out_last_d;
  logic             out_empty_q, out_empty_d;

  assign in_key   = s_axis_tdata[KEY_W-1:0];
  assign in_value = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];

  // Input handshake.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ins_acc       = in_acc && (s_axis_tuser == KIND_INSERT);
  assign dump_acc      = in_acc && (s_axis_tuser == KIND_DUMP);

  // Limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIM_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Clamp the limit into the range one to the depth.
  always_comb begin
    lim_ext = CMP_W'(limit_q);
    eff_lim = lim_ext;
    if (lim_ext == '0) begin
      eff_lim = CMP_W'(1);
    end else if (lim_ext > CMP_W'(DEPTH)) begin
      eff_lim = CMP_W'(DEPTH);
    end
  end

  // Insert decision: grow while below the limit, else evict the minimum
  // only if some held key is smaller than the offered one.
  assign room  = CMP_W'(count_q) < eff_lim;
  assign evict = |cell_lt;

  assign out_free = !out_valid_q || m_axis_tready;
  assign emit     = (state_q == ST_DUMP) && out_free;

  always_comb begin
    ctrl.ins_en = ins_acc && (room || evict);
    ctrl.grow   = ins_acc && room;
    ctrl.shift  = emit && (rem_q != '0);
  end

  // Cell chain.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             prev_stay;
    logic             prev_valid;
    logic [KEY_W-1:0] prev_key;
    logic [VAL_W-1:0] prev_value;
    logic             next_valid;
    logic [KEY_W-1:0] next_key;
    logic [VAL_W-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_stay  = 1'b1;
      assign prev_valid = 1'b1;
      assign prev_key   = in_key;
      assign prev_value = in_value;
    end else begin : g_mid
      assign prev_stay  = cell_stay[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_key   = cell_key[0];
      assign next_value = cell_value[0];
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_key   = cell_key[i+1];
      assign next_value = cell_value[i+1];
    end

    tns_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .in_key_i     (in_key),
      .in_value_i   (in_value),
      .prev_stay_i  (prev_stay),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_value_i (prev_value),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .next_value_i (next_value),
      .head_key_i   (cell_key[0]),
      .head_value_i (cell_value[0]),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .stay_o       (cell_stay[i]),
      .lt_o         (cell_lt[i])
    );
  end

  // Sequencer: held count, dump countdown and the output load.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_key_d   = out_key_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    case (state_q)
      ST_IDLE: begin
        if (ctrl.grow) begin
          count_d = count_q + CNT_W'(1);
        end
        if (dump_acc) begin
          rem_d   = count_q;
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (emit) begin
          if (rem_q == '0) begin
            out_key_d   = '0;
            out_value_d = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            out_key_d   = cell_key[0];
            out_value_d = cell_value[0];
            out_last_d  = (rem_q == CNT_W'(1));
            out_empty_d = 1'b0;
            rem_d       = rem_q - CNT_W'(1);
            if (rem_q == CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_key_q   <= out_key_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_value_q, out_key_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_empty_q;

endmodule : top_n_selector

`default_nettype wire

// File: verif/top_n_selector_tb.sv
// ----------------------------------------------------------------------------
// top_n_selector_tb
// Self-checking bench for the top-N selector. A directed table covers the
// empty dump, extreme keys, equal keys and out-of-range and lowered limits.
// Random phases follow, each under its own limit and idling mix. Every dump
// transaction is predicted from a sorted copy of the store or, for typed rows,
// from the table; the output stream is compared pair by pair against it.
// ----------------------------------------------------------------------------
module top_n_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tns_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_DIR          = 21;
  localparam int N_PHASES       = 9;
  localparam int HOLD_PHASE     = 5;
  localparam int DRAIN_PHASE    = 6;

  // One pair as it leaves the output stream.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             empty;
  } ranked_pair_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

  // One row of the directed table: either a transaction or a limit write.
  typedef struct packed {
    row_op_e          op;
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [LIM_W-1:0] limit;
    logic             typed;
    ranked_pair_t     want;
  } stim_row_t;

  localparam ranked_pair_t NO_PAIR = '{32'h0, 32'h0, 1'b0, 1'b0};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIM_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [63:0]        m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tuser;

  // Predicted store contents, largest key first.
  logic [KEY_W-1:0]   rank_key [DEPTH];
  logic [VAL_W-1:0]   rank_val [DEPTH];
  int unsigned        rank_count;
  logic [LIM_W-1:0]   rank_limit;

  ranked_pair_t       pending_pairs [$];
  ranked_pair_t       typed_want;
  ranked_pair_t       got_pair;
  ranked_pair_t       want_pair;
  logic               use_typed;

  int                 src_gap_pct;
  int                 sink_stall_pct;
  logic               hold_request;
  logic [KEY_W-1:0]   ramp_key;

  int                 error_count;
  int                 inserts_seen;
  int                 dumps_seen;
  int                 pairs_checked;
  int                 run_pairs;
  int                 longest_dump;
  int                 quiet_cycles;

  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_ITEM, KIND_DUMP,   32'h0,        32'h0,        5'd0,  1'b1,
      '{32'h0, 32'h0, 1'b1, 1'b1}},
    '{ROW_CFG,  KIND_INSERT, 32'h0,        32'h0,        5'd1,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'hFFFFFFFF, 32'h0,        5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h0,        32'hFFFFFFFF, 5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_DUMP,   32'h0,        32'h0,        5'd0,  1'b1,
      '{32'hFFFFFFFF, 32'h0, 1'b1, 1'b0}},
    '{ROW_CFG,  KIND_INSERT, 32'h0,        32'h0,        5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h5,        32'h5,        5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_DUMP,   32'h0,        32'h0,        5'd0,  1'b1,
      '{32'hFFFFFFFF, 32'h0, 1'b1, 1'b0}},
    '{ROW_CFG,  KIND_INSERT, 32'h0,        32'h0,        5'd31, 1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h7,        32'h1,        5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h7,        32'h2,        5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h0,        32'h3,        5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h80000000, 32'h4,        5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h0,        32'hAAAAAAAA, 5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_DUMP,   32'h0,        32'h0,        5'd0,  1'b0, NO_PAIR},
    '{ROW_CFG,  KIND_INSERT, 32'h0,        32'h0,        5'd2,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h1,        32'h55555555, 5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_INSERT, 32'h0,        32'h6,        5'd0,  1'b0, NO_PAIR},
    '{ROW_ITEM, KIND_DUMP,   32'h0,        32'h0,        5'd0,  1'b0, NO_PAIR},
    '{ROW_CFG,  KIND_INSERT, 32'h0,        32'h0,        5'd16, 1'b0, NO_PAIR}
  };

  // Random phases: limit written first, then the idling mix and item count.
  int phase_limit [N_PHASES] = '{16, 4, 1, 31, 0, 8, 16, 2, 12};
  int phase_src   [N_PHASES] = '{0, 61, 0, 26, 0, 0, 26, 61, 0};
  int phase_sink  [N_PHASES] = '{0, 0, 61, 26, 0, 61, 26, 0, 0};
  int phase_items [N_PHASES] = '{55, 50, 45, 60, 35, 45, 60, 40, 45};

  top_n_selector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Effective limit: zero keeps one pair, anything above the depth keeps DEPTH.
  function automatic int unsigned kept_limit();
    int unsigned lim;
    lim = rank_limit;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    return lim;
  endfunction

  // Place a pair below every held key that is not smaller than it.
  function automatic void place_ranked(input logic [KEY_W-1:0] k,
                                       input logic [VAL_W-1:0] v);
    int unsigned pos;
    pos = 0;
    while (pos < rank_count && rank_key[pos] >= k) pos++;
    for (int unsigned i = rank_count; i > pos; i--) begin
      rank_key[i] = rank_key[i-1];
      rank_val[i] = rank_val[i-1];
    end
    rank_key[pos] = k;
    rank_val[pos] = v;
    rank_count++;
  endfunction

  // Apply one accepted transaction to the predicted store; a dump queues the
  // pairs the block must emit.
  function automatic void rank_step(input logic kind, input logic [KEY_W-1:0] k,
                                    input logic [VAL_W-1:0] v);
    if (kind == KIND_INSERT) begin
      if (rank_count < kept_limit()) begin
        place_ranked(k, v);
      end else if (rank_count > 0 && k > rank_key[rank_count-1]) begin
        rank_count--;
        place_ranked(k, v);
      end
    end else if (rank_count == 0) begin
      pending_pairs.push_back('{32'h0, 32'h0, 1'b1, 1'b1});
    end else begin
      for (int unsigned i = 0; i < rank_count; i++) begin
        pending_pairs.push_back('{rank_key[i], rank_val[i], i + 1 == rank_count, 1'b0});
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one transaction after a random gap; returns at the falling edge
  // that follows its acceptance.
  task automatic offer(input logic kind, input logic [KEY_W-1:0] k,
                       input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {v, k};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted pair has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_pairs.size() != 0) @(negedge clk_i);
  endtask

  // Limit writes happen only with the block idle.
  task automatic write_limit(input logic [LIM_W-1:0] lim);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Sample both streams and the limit port at the rising edge; compare output
  // pairs, advance the prediction, and watch for a stuck run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_pair = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast, m_axis_tuser};
        run_pairs++;
        if (m_axis_tlast) begin
          if (run_pairs > longest_dump) longest_dump = run_pairs;
          run_pairs = 0;
        end
        if (pending_pairs.size() == 0) begin
          report_mismatch($sformatf("pair %h/%h arrived with nothing pending",
                                    got_pair.key, got_pair.value));
        end else begin
          want_pair = pending_pairs.pop_front();
          pairs_checked++;
          if (got_pair.key !== want_pair.key)
            report_mismatch($sformatf("out_key got %h expected %h",
                                      got_pair.key, want_pair.key));
          if (got_pair.value !== want_pair.value)
            report_mismatch($sformatf("out_value got %h expected %h",
                                      got_pair.value, want_pair.value));
          if (got_pair.last !== want_pair.last)
            report_mismatch($sformatf("last got %b expected %b",
                                      got_pair.last, want_pair.last));
          if (got_pair.empty !== want_pair.empty)
            report_mismatch($sformatf("empty_res got %b expected %b",
                                      got_pair.empty, want_pair.empty));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_DUMP) dumps_seen++;
        else inserts_seen++;
        if (s_axis_tuser == KIND_DUMP && use_typed) pending_pairs.push_back(typed_want);
        else rank_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
      end
      if (cfg_we_i) rank_limit = cfg_wdata_i;
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    logic             kind;
    logic [KEY_W-1:0] key;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = KIND_INSERT;
    m_axis_tready  = 1'b0;
    rank_count     = 0;
    rank_limit     = LIM_RESET;
    use_typed      = 1'b0;
    typed_want     = NO_PAIR;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    hold_request   = 1'b0;
    ramp_key       = '0;
    error_count    = 0;
    inserts_seen   = 0;
    dumps_seen     = 0;
    pairs_checked  = 0;
    run_pairs      = 0;
    longest_dump   = 0;
    quiet_cycles   = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].op == ROW_CFG) begin
        write_limit(dir_rows[r].limit);
      end else begin
        use_typed  = dir_rows[r].typed;
        typed_want = dir_rows[r].want;
        offer(dir_rows[r].kind, dir_rows[r].key, dir_rows[r].value);
        use_typed  = 1'b0;
      end
    end

    // Random phases. Keys mix small values (many ties), full-range values,
    // extremes, keys at or just above the held minimum, and a rising ramp.
    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(LIM_W'(phase_limit[p]));
      src_gap_pct    = phase_src[p];
      sink_stall_pct = phase_sink[p];
      if (p == HOLD_PHASE) hold_request = 1'b1;
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == DRAIN_PHASE && i == phase_items[p] / 2) wait_drained();
        kind = ($urandom_range(7) == 0) ? KIND_DUMP : KIND_INSERT;
        if (p == HOLD_PHASE && i == 0) kind = KIND_DUMP;
        case ($urandom_range(5))
          0: key = $urandom_range(7);
          1, 2: key = $urandom;
          3: begin
            case ($urandom_range(3))
              0: key = 32'h0;
              1: key = 32'hFFFFFFFF;
              2: key = 32'h80000000;
              default: key = 32'h7FFFFFFF;
            endcase
          end
          4: key = (rank_count > 0) ? rank_key[rank_count-1] + $urandom_range(1)
                                    : $urandom;
          default: begin
            ramp_key = ramp_key + $urandom_range(1, 1000);
            key = ramp_key;
          end
        endcase
        offer(kind, key, $urandom);
      end
    end

    // Let the last dump drain, then let the block idle before the summary.
    wait_drained();
    src_gap_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Summary: %0d inserts and %0d dumps accepted, %0d pairs checked, longest dump %0d",
             inserts_seen, dumps_seen, pairs_checked, longest_dump);
    $display("Summary: limits 0 to 31 incl. lowered below count, hold-off and drain pause");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
